// ----- rtl/gud_pkg.sv -----
// ---------------------------------------------------------------------------
// gud_pkg
// Shared types and widths for the generalized unifrac distance block.
// ---------------------------------------------------------------------------
package gud_pkg;

  localparam int unsigned SHARE_W  = 16;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned ALPHA_W  = 9;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned CSUB_W   = 50;
  localparam int unsigned MUL_W    = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 9'd256;

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_PMUL = 14'b00000000000010,
    ST_PWB  = 14'b00000000000100,
    ST_ADV  = 14'b00000000001000,
    ST_SQRT = 14'b00000000010000,
    ST_WMUL = 14'b00000000100000,
    ST_WWB  = 14'b00000001000000,
    ST_TMUL = 14'b00000010000000,
    ST_TWB  = 14'b00000100000000,
    ST_TDIV = 14'b00001000000000,
    ST_ACC  = 14'b00010000000000,
    ST_FIN  = 14'b00100000000000,
    ST_FDIV = 14'b01000000000000,
    ST_OUT  = 14'b10000000000000
  } state_t;

endpackage

// ----- rtl/gud_if.sv -----
// ---------------------------------------------------------------------------
// gud_if
// Valid/ready channels of the generalized unifrac distance block.
// ---------------------------------------------------------------------------
interface gud_branch_if;
  logic                        valid;
  logic                        ready;
  logic [gud_pkg::SHARE_W-1:0] first_share;
  logic [gud_pkg::SHARE_W-1:0] second_share;
  logic [gud_pkg::LEN_W-1:0]   branch_length;
  logic                        last_branch;

  modport source (output valid, first_share, second_share, branch_length, last_branch,
                  input ready);
  modport sink (input valid, first_share, second_share, branch_length, last_branch,
                output ready);
endinterface

interface gud_result_if;
  logic                       valid;
  logic                       ready;
  logic [gud_pkg::DIST_W-1:0] distance;
  logic                       undefined_result;

  modport source (output valid, distance, undefined_result, input ready);
  modport sink (input valid, distance, undefined_result, output ready);
endinterface

interface gud_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [gud_pkg::ALPHA_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/gud_mul.sv -----
// ---------------------------------------------------------------------------
// gud_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module gud_mul (
  input  logic                          clk,
  input  logic [gud_pkg::MUL_W-1:0]     a,
  input  logic [gud_pkg::MUL_W-1:0]     b,
  output logic [2*gud_pkg::MUL_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- rtl/gud_csub.sv -----
// ---------------------------------------------------------------------------
// gud_csub
// Shared compare-subtract step for the sqrt and divide iterations.
// ---------------------------------------------------------------------------
module gud_csub (
  input  logic [gud_pkg::CSUB_W-1:0] a,
  input  logic [gud_pkg::CSUB_W-1:0] b,
  output logic                       ge,
  output logic [gud_pkg::CSUB_W-1:0] diff
);

  logic [gud_pkg::CSUB_W:0] sub;

  assign sub  = {1'b0, a} - {1'b0, b};
  assign ge   = ~sub[gud_pkg::CSUB_W];
  assign diff = sub[gud_pkg::CSUB_W-1:0];

endmodule

// ----- rtl/generalized_unifrac_distance.sv -----
// ---------------------------------------------------------------------------
// generalized_unifrac_distance
// Generalized unifrac accumulator over tree branches with a shared
// multiplier and a shared compare-subtract unit under one sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   branch_in  : one transaction per tree branch (shares, length, last flag).
//   result_out : one transaction per pair, after the branch marked last;
//                distance in Q0.16, undefined_result when the weight sum is 0.
//   cfg        : writes alpha_exponent (Q1.8); always ready, write only idle.
// Sequence:
//   a branch with both shares zero is accepted and skips the arithmetic.
//   Otherwise the sequencer accepts it and runs nine advance steps, eight
//   square roots on the compare-subtract unit, up to nine power multiplies,
//   the weight and term multiplies, a divide for the numerator term and one
//   accumulate step. The last branch adds a setup step, a final divide and
//   a load of the result register.
//   branch_in is ready only while the sequencer is idle.
// Reset: alpha_exponent returns to 0.5 and both sums clear.
// Stall: a result waits in the output register while branches of the next
//   pair are taken; the final step of that pair holds until the register
//   is empty.
// ---------------------------------------------------------------------------
module generalized_unifrac_distance (
  input  logic          clk,
  input  logic          rst,
  gud_branch_if.sink    branch_in,
  gud_result_if.source  result_out,
  gud_cfg_if.sink       cfg
);

  gud_pkg::state_t state;

  logic [gud_pkg::ALPHA_W-1:0] alpha;
  logic [gud_pkg::ALPHA_W-1:0] a_r;
  logic [16:0]                 ssum;
  logic [15:0]                 diff;
  logic [23:0]                 blen;
  logic                        last_r;
  logic [31:0]                 xr;
  logic [31:0]                 pr;
  logic [2:0]                  bi;
  logic                        first;
  logic [61:0]                 rad;
  logic [49:0]                 rem;
  logic [30:0]                 root;
  logic [63:0]                 dvd;
  logic [47:0]                 dvs;
  logic [5:0]                  cnt;
  logic [24:0]                 wr;
  logic [47:0]                 num;
  logic [47:0]                 den;
  logic                        ov;
  logic [15:0]                 dist_q;
  logic                        undef_q;

  logic [16:0] ssum_in;
  logic [15:0] diff_in;
  logic [8:0]  aeff;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [49:0] cs_a;
  logic [49:0] cs_b;
  logic        cs_ge;
  logic [49:0] cs_diff;
  logic [30:0] root_next;
  logic [63:0] dvd_next;
  logic [48:0] num_add;
  logic [48:0] den_add;
  logic        out_free;
  logic        accept;

  assign accept   = branch_in.valid && branch_in.ready;
  assign out_free = !ov || result_out.ready;

  assign branch_in.ready        = (state == gud_pkg::ST_IDLE);
  assign cfg.ready              = 1'b1;
  assign result_out.valid       = ov;
  assign result_out.distance    = dist_q;
  assign result_out.undefined_result = undef_q;

  assign ssum_in = {1'b0, branch_in.first_share} + {1'b0, branch_in.second_share};
  assign diff_in = (branch_in.first_share > branch_in.second_share)
                 ? branch_in.first_share - branch_in.second_share
                 : branch_in.second_share - branch_in.first_share;
  assign aeff    = (alpha > gud_pkg::ALPHA_MAX) ? gud_pkg::ALPHA_MAX : alpha;

  always_comb begin
    case (state)
      gud_pkg::ST_PMUL: begin
        mul_a = pr;
        mul_b = xr;
      end
      gud_pkg::ST_WMUL: begin
        mul_a = {8'b0, blen};
        mul_b = pr;
      end
      gud_pkg::ST_TMUL: begin
        mul_a = {7'b0, wr};
        mul_b = {16'b0, diff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gud_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // sqrt brings down two radicand bits, divide brings down one
  always_comb begin
    if (state == gud_pkg::ST_SQRT) begin
      cs_a = {rem[47:0], rad[61:60]};
      cs_b = {17'b0, root, 2'b01};
    end else begin
      cs_a = {rem[48:0], dvd[63]};
      cs_b = {2'b0, dvs};
    end
  end

  gud_csub u_csub (
    .a    (cs_a),
    .b    (cs_b),
    .ge   (cs_ge),
    .diff (cs_diff)
  );

  assign root_next = {root[29:0], cs_ge};
  assign dvd_next  = {dvd[62:0], cs_ge};
  assign num_add   = {1'b0, num} + {24'b0, dvd[24:0]};
  assign den_add   = {1'b0, den} + {24'b0, wr};

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= gud_pkg::ALPHA_RESET;
    end else if (cfg.valid && cfg.ready) begin
      alpha <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gud_pkg::ST_IDLE;
      num   <= '0;
      den   <= '0;
      ov    <= 1'b0;
    end else begin
      if (state == gud_pkg::ST_OUT && out_free) begin
        ov <= 1'b1;
      end else if (ov && result_out.ready) begin
        ov <= 1'b0;
      end
      unique case (state)
        gud_pkg::ST_IDLE: begin
          if (accept) begin
            ssum   <= ssum_in;
            diff   <= diff_in;
            blen   <= branch_in.branch_length;
            last_r <= branch_in.last_branch;
            a_r    <= aeff;
            xr     <= {1'b0, ssum_in, 14'b0};
            pr     <= 32'h4000_0000;
            bi     <= 3'd7;
            first  <= 1'b1;
            if (ssum_in == 17'd0) begin
              state <= branch_in.last_branch ? gud_pkg::ST_FIN : gud_pkg::ST_IDLE;
            end else if (aeff[8]) begin
              state <= gud_pkg::ST_PMUL;
            end else begin
              state <= gud_pkg::ST_ADV;
            end
          end
        end
        gud_pkg::ST_PMUL: begin
          state <= gud_pkg::ST_PWB;
        end
        gud_pkg::ST_PWB: begin
          pr    <= prod[61:30];
          state <= gud_pkg::ST_ADV;
        end
        gud_pkg::ST_ADV: begin
          if (!first && bi == 3'd0) begin
            state <= gud_pkg::ST_WMUL;
          end else begin
            if (!first) begin
              bi <= bi - 3'd1;
            end
            first <= 1'b0;
            rad   <= {xr, 30'b0};
            rem   <= '0;
            root  <= '0;
            cnt   <= 6'd30;
            state <= gud_pkg::ST_SQRT;
          end
        end
        gud_pkg::ST_SQRT: begin
          rem  <= cs_ge ? cs_diff : cs_a;
          root <= root_next;
          rad  <= {rad[59:0], 2'b00};
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            xr    <= {1'b0, root_next};
            state <= a_r[bi] ? gud_pkg::ST_PMUL : gud_pkg::ST_ADV;
          end
        end
        gud_pkg::ST_WMUL: begin
          state <= gud_pkg::ST_WWB;
        end
        gud_pkg::ST_WWB: begin
          wr    <= prod[54:30];
          state <= gud_pkg::ST_TMUL;
        end
        gud_pkg::ST_TMUL: begin
          state <= gud_pkg::ST_TWB;
        end
        gud_pkg::ST_TWB: begin
          dvd   <= {prod[40:0], 23'b0};
          dvs   <= {31'b0, ssum};
          rem   <= '0;
          cnt   <= 6'd40;
          state <= gud_pkg::ST_TDIV;
        end
        gud_pkg::ST_TDIV: begin
          rem <= cs_ge ? cs_diff : cs_a;
          dvd <= dvd_next;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= gud_pkg::ST_ACC;
          end
        end
        gud_pkg::ST_ACC: begin
          num   <= num_add[48] ? {48{1'b1}} : num_add[47:0];
          den   <= den_add[48] ? {48{1'b1}} : den_add[47:0];
          state <= last_r ? gud_pkg::ST_FIN : gud_pkg::ST_IDLE;
        end
        gud_pkg::ST_FIN: begin
          // hold while the previous result still sits in the output register
          if (!ov) begin
            if (den == 48'd0) begin
              dist_q  <= '0;
              undef_q <= 1'b1;
              state   <= gud_pkg::ST_OUT;
            end else begin
              dvd     <= {num, 16'b0};
              dvs     <= den;
              rem     <= '0;
              cnt     <= 6'd63;
              undef_q <= 1'b0;
              state   <= gud_pkg::ST_FDIV;
            end
          end
        end
        gud_pkg::ST_FDIV: begin
          rem <= cs_ge ? cs_diff : cs_a;
          dvd <= dvd_next;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            dist_q <= (dvd_next[63:16] != 48'd0) ? 16'hFFFF : dvd_next[15:0];
            state  <= gud_pkg::ST_OUT;
          end
        end
        gud_pkg::ST_OUT: begin
          if (out_free) begin
            num   <= '0;
            den   <= '0;
            state <= gud_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= gud_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
